// ===== design/hsvwcd_pkg.sv =====
// Shared constants for the HSV weighted color distance block.
package hsvwcd_pkg;

  localparam int unsigned ChanW  = 8;   // one pixel channel or register
  localparam int unsigned ModW   = 7;   // hue difference modulo the wrap
  localparam int unsigned ProdW  = 16;  // distance times weight
  localparam int unsigned SumW   = 18;  // weighted sum, max 194310
  localparam int unsigned NumW   = 20;  // three times the sum, max 582930
  localparam int unsigned WSumW  = 10;  // sum of the weights, max 765
  localparam int unsigned AddrW  = 5;   // byte address, six 32-bit registers
  localparam int unsigned IdxW   = 3;   // register index
  localparam int unsigned DataW  = 32;
  localparam int unsigned Latency = 8;  // start to result strobe

  localparam logic [ChanW-1:0] HueWrap  = 8'd127;
  localparam logic [ChanW-1:0] HueWrap2 = 8'd254;
  localparam logic [ChanW-1:0] DistMax  = 8'd255;

  localparam logic [IdxW-1:0] RegTargetHue = 3'd0;
  localparam logic [IdxW-1:0] RegTargetSat = 3'd1;
  localparam logic [IdxW-1:0] RegTargetVal = 3'd2;
  localparam logic [IdxW-1:0] RegHueWeight = 3'd3;
  localparam logic [IdxW-1:0] RegSatWeight = 3'd4;
  localparam logic [IdxW-1:0] RegValWeight = 3'd5;
  localparam logic [IdxW-1:0] NumRegs      = 3'd6;

endpackage

// ===== design/hsv_weighted_color_distance.sv =====
// Top level: pipelined weighted HSV distance of a pixel to a target color.
//
// One pixel is taken on every clock cycle in which start is high; busy
// stays low. The result appears on color_distance_o with
// color_distance_valid_o high for one cycle, once the pixel has passed all
// stages, one result per pixel in order. The 8 register stages are: channel
// differences, the three weight multipliers, the weighted sum times three,
// and five stages of a restoring divider by the weight sum that resolve the
// saturation check and the eight quotient bits (one or two bits a stage).
// Results cannot be held off. Program the target and weights over the APB
// port only while no pixel is in flight.
module hsv_weighted_color_distance (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [hsvwcd_pkg::ChanW-1:0]    pixel_hue_i,
  input  logic [hsvwcd_pkg::ChanW-1:0]    pixel_sat_i,
  input  logic [hsvwcd_pkg::ChanW-1:0]    pixel_val_i,
  output logic [hsvwcd_pkg::ChanW-1:0]    color_distance_o,
  output logic                            color_distance_valid_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hsvwcd_pkg::AddrW-1:0]    paddr,
  input  logic [hsvwcd_pkg::DataW-1:0]    pwdata,
  output logic [hsvwcd_pkg::DataW-1:0]    prdata,
  output logic                            pready
);

  localparam int unsigned CW = hsvwcd_pkg::ChanW;
  localparam int unsigned NW = hsvwcd_pkg::NumW;

  // ---------------- configuration ----------------
  logic [CW-1:0] target_hue_q, target_sat_q, target_val_q;
  logic [CW-1:0] hue_weight_q, sat_weight_q, val_weight_q;
  logic [hsvwcd_pkg::IdxW-1:0] reg_idx;
  logic          cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[hsvwcd_pkg::AddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_hue_q <= '0;
      target_sat_q <= '0;
      target_val_q <= '0;
      hue_weight_q <= '0;
      sat_weight_q <= '0;
      val_weight_q <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        hsvwcd_pkg::RegTargetHue: target_hue_q <= pwdata[CW-1:0];
        hsvwcd_pkg::RegTargetSat: target_sat_q <= pwdata[CW-1:0];
        hsvwcd_pkg::RegTargetVal: target_val_q <= pwdata[CW-1:0];
        hsvwcd_pkg::RegHueWeight: hue_weight_q <= pwdata[CW-1:0];
        hsvwcd_pkg::RegSatWeight: sat_weight_q <= pwdata[CW-1:0];
        hsvwcd_pkg::RegValWeight: val_weight_q <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      hsvwcd_pkg::RegTargetHue: prdata[CW-1:0] = target_hue_q;
      hsvwcd_pkg::RegTargetSat: prdata[CW-1:0] = target_sat_q;
      hsvwcd_pkg::RegTargetVal: prdata[CW-1:0] = target_val_q;
      hsvwcd_pkg::RegHueWeight: prdata[CW-1:0] = hue_weight_q;
      hsvwcd_pkg::RegSatWeight: prdata[CW-1:0] = sat_weight_q;
      hsvwcd_pkg::RegValWeight: prdata[CW-1:0] = val_weight_q;
      default: prdata = '0;
    endcase
  end

  // The user must change weights only while idle (not enforced), so the sum is a static divisor.
  logic [hsvwcd_pkg::WSumW-1:0] w_sum;
  logic [NW-1:0]                w_ext;
  logic                         w_zero;
  assign w_sum  = {2'b0, hue_weight_q} + {2'b0, sat_weight_q} + {2'b0, val_weight_q};
  assign w_ext  = {{(NW - hsvwcd_pkg::WSumW){1'b0}}, w_sum};
  assign w_zero = (w_sum == '0);

  assign busy = 1'b0;

  // One restoring division step: {quotient bit, new remainder}.
  function automatic logic [NW:0] div_step(input logic [NW-1:0] rem,
                                           input logic [NW-1:0] dsh);
    logic ge;
    ge = (rem >= dsh);
    return {ge, ge ? (rem - dsh) : rem};
  endfunction

  function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a,
                                             input logic [CW-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // ---------------- stage 1: channel distances ----------------
  logic [CW-1:0] hdiff, hmod_full;
  logic          s1_vld_q;
  logic [CW-1:0] hd1_q, sd1_q, vd1_q;

  assign hdiff = abs_diff(target_hue_q, pixel_hue_i);
  always_comb begin
    if (hdiff >= hsvwcd_pkg::HueWrap2)     hmod_full = hdiff - hsvwcd_pkg::HueWrap2;
    else if (hdiff >= hsvwcd_pkg::HueWrap) hmod_full = hdiff - hsvwcd_pkg::HueWrap;
    else                                   hmod_full = hdiff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_vld_q <= 1'b0;
    else         s1_vld_q <= start;
  end

  always_ff @(posedge clk_i) begin
    hd1_q <= {hmod_full[hsvwcd_pkg::ModW-1:0], 1'b0};
    sd1_q <= abs_diff(target_sat_q, pixel_sat_i);
    vd1_q <= abs_diff(target_val_q, pixel_val_i);
  end

  // ---------------- stage 2: weight products ----------------
  logic                        s2_vld_q;
  logic [hsvwcd_pkg::ProdW-1:0] hp2_q, sp2_q, vp2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_vld_q <= 1'b0;
    else         s2_vld_q <= s1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    hp2_q <= hd1_q * hue_weight_q;
    sp2_q <= sd1_q * sat_weight_q;
    vp2_q <= vd1_q * val_weight_q;
  end

  // ---------------- stage 3: numerator 3*S ----------------
  logic                        s3_vld_q;
  logic [NW-1:0]               num3_q;
  logic [hsvwcd_pkg::SumW-1:0] wsum;
  logic [NW-1:0]               wsum_ext;

  assign wsum = {2'b0, hp2_q} + {2'b0, sp2_q} + {2'b0, vp2_q};
  assign wsum_ext = {{(NW - hsvwcd_pkg::SumW){1'b0}}, wsum};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_vld_q <= 1'b0;
    else         s3_vld_q <= s2_vld_q;
  end

  always_ff @(posedge clk_i) begin
    num3_q <= wsum_ext + {wsum_ext[NW-2:0], 1'b0};
  end

  // ---------------- stage 4: saturation check, quotient bit 7 ----------------
  logic          s4_vld_q, ovf4_q;
  logic [NW-1:0] rem4_q;
  logic [CW-1:0] quo4_q;
  logic [NW:0]   st4;

  assign st4 = div_step(num3_q, w_ext << 7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_vld_q <= 1'b0;
    else         s4_vld_q <= s3_vld_q;
  end

  always_ff @(posedge clk_i) begin
    ovf4_q <= (num3_q >= (w_ext << 8));
    rem4_q <= st4[NW-1:0];
    quo4_q <= {st4[NW], 7'b0};
  end

  // ---------------- stage 5: bits 6 and 5 ----------------
  logic          s5_vld_q, ovf5_q;
  logic [NW-1:0] rem5_q;
  logic [CW-1:0] quo5_q;
  logic [NW:0]   st5a, st5b;

  assign st5a = div_step(rem4_q, w_ext << 6);
  assign st5b = div_step(st5a[NW-1:0], w_ext << 5);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s5_vld_q <= 1'b0;
    else         s5_vld_q <= s4_vld_q;
  end

  always_ff @(posedge clk_i) begin
    ovf5_q <= ovf4_q;
    rem5_q <= st5b[NW-1:0];
    quo5_q <= {quo4_q[7], st5a[NW], st5b[NW], 5'b0};
  end

  // ---------------- stage 6: bits 4 and 3 ----------------
  logic          s6_vld_q, ovf6_q;
  logic [NW-1:0] rem6_q;
  logic [CW-1:0] quo6_q;
  logic [NW:0]   st6a, st6b;

  assign st6a = div_step(rem5_q, w_ext << 4);
  assign st6b = div_step(st6a[NW-1:0], w_ext << 3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s6_vld_q <= 1'b0;
    else         s6_vld_q <= s5_vld_q;
  end

  always_ff @(posedge clk_i) begin
    ovf6_q <= ovf5_q;
    rem6_q <= st6b[NW-1:0];
    quo6_q <= {quo5_q[7:5], st6a[NW], st6b[NW], 3'b0};
  end

  // ---------------- stage 7: bits 2 and 1 ----------------
  logic          s7_vld_q, ovf7_q;
  logic [NW-1:0] rem7_q;
  logic [CW-1:0] quo7_q;
  logic [NW:0]   st7a, st7b;

  assign st7a = div_step(rem6_q, w_ext << 2);
  assign st7b = div_step(st7a[NW-1:0], w_ext << 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s7_vld_q <= 1'b0;
    else         s7_vld_q <= s6_vld_q;
  end

  always_ff @(posedge clk_i) begin
    ovf7_q <= ovf6_q;
    rem7_q <= st7b[NW-1:0];
    quo7_q <= {quo6_q[7:3], st7a[NW], st7b[NW], 1'b0};
  end

  // ---------------- stage 8: bit 0, saturation, zero weights ----------------
  logic          out_vld_q;
  logic [CW-1:0] dist_q, dist_d;
  logic [NW:0]   st8;

  assign st8 = div_step(rem7_q, w_ext);

  always_comb begin
    if (w_zero)      dist_d = '0;
    else if (ovf7_q) dist_d = hsvwcd_pkg::DistMax;
    else             dist_d = {quo7_q[7:1], st8[NW]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else         out_vld_q <= s7_vld_q;
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
  end

  assign color_distance_o       = dist_q;
  assign color_distance_valid_o = out_vld_q;

endmodule

// ===== design/hsvwcd_checker.sv =====
// Port-level assertions for the HSV weighted color distance block, with bind.
module hsvwcd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         color_distance_valid_o,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [hsvwcd_pkg::AddrW-1:0] paddr,
  input logic [hsvwcd_pkg::DataW-1:0] pwdata,
  input logic [hsvwcd_pkg::DataW-1:0] prdata
);

  // Every accepted pixel produces exactly one result strobe.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##8 color_distance_valid_o)
    else $error("accepted item gave no result after fixed latency");

  a_no_stray_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    color_distance_valid_o |-> $past(start && !busy, hsvwcd_pkg::Latency))
    else $error("result strobe without matching accepted item");

  // A register reads back the low byte that was just written to it.
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && !pwrite && $past(psel && penable && pwrite) && paddr == $past(paddr)
     && paddr[hsvwcd_pkg::AddrW-1:2] < hsvwcd_pkg::NumRegs)
    |-> prdata == {24'b0, $past(pwdata[7:0])})
    else $error("register readback mismatch");

endmodule

bind hsv_weighted_color_distance hsvwcd_checker u_checker (.*);

// ===== verif/tb_hsv_weighted_color_distance.sv =====
// Self-checking testbench for the HSV weighted color distance block.
module tb_hsv_weighted_color_distance;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ChanW   = hsvwcd_pkg::ChanW;
  localparam int unsigned AddrW   = hsvwcd_pkg::AddrW;
  localparam int unsigned DataW   = hsvwcd_pkg::DataW;
  localparam int unsigned IdxW    = hsvwcd_pkg::IdxW;
  localparam int unsigned WSumW   = hsvwcd_pkg::WSumW;
  localparam int unsigned NumW    = hsvwcd_pkg::NumW;
  localparam int unsigned Latency = hsvwcd_pkg::Latency;
  localparam logic [ChanW-1:0] HueWrap = hsvwcd_pkg::HueWrap;
  localparam logic [ChanW-1:0] DistMax = hsvwcd_pkg::DistMax;
  localparam logic [IdxW-1:0]  NumRegs = hsvwcd_pkg::NumRegs;

  typedef struct packed {
    logic [ChanW-1:0] hue;
    logic [ChanW-1:0] sat;
    logic [ChanW-1:0] val;
  } pixel_t;

  localparam int unsigned DistScale  = 3;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned PhaseItems = 135;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [ChanW-1:0]  pixel_hue_i = '0;
  logic [ChanW-1:0]  pixel_sat_i = '0;
  logic [ChanW-1:0]  pixel_val_i = '0;
  logic [ChanW-1:0]  color_distance_o;
  logic              color_distance_valid_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;

  pixel_t            pending_pixels[$];
  logic [ChanW-1:0]  expected_distances[$];
  logic [ChanW-1:0]  target_and_weights [NumRegs] = '{default: '0};
  int unsigned       send_idle_pct = 0;
  int unsigned       error_count = 0;
  int unsigned       quiet_cycles = 0;
  logic [ChanW-1:0]  exp_distance;

  hsv_weighted_color_distance dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic logic [ChanW-1:0] abs_diff(logic [ChanW-1:0] a,
                                                logic [ChanW-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [ChanW-1:0] weighted_distance(pixel_t px);
    logic [ChanW-1:0] hue_dist;
    logic [WSumW-1:0] weight_sum;
    logic [NumW-1:0]  scaled_sum;
    logic [NumW-1:0]  quotient;
    // hue wraps: a difference of 127 counts as no difference
    hue_dist = ChanW'(2 * (abs_diff(target_and_weights[hsvwcd_pkg::RegTargetHue], px.hue)
                           % HueWrap));
    weight_sum = WSumW'(target_and_weights[hsvwcd_pkg::RegHueWeight])
               + WSumW'(target_and_weights[hsvwcd_pkg::RegSatWeight])
               + WSumW'(target_and_weights[hsvwcd_pkg::RegValWeight]);
    scaled_sum = NumW'(DistScale) * (
        NumW'(hue_dist) * NumW'(target_and_weights[hsvwcd_pkg::RegHueWeight])
      + NumW'(abs_diff(target_and_weights[hsvwcd_pkg::RegTargetSat], px.sat))
        * NumW'(target_and_weights[hsvwcd_pkg::RegSatWeight])
      + NumW'(abs_diff(target_and_weights[hsvwcd_pkg::RegTargetVal], px.val))
        * NumW'(target_and_weights[hsvwcd_pkg::RegValWeight]));
    if (weight_sum == '0) return '0;
    quotient = scaled_sum / NumW'(weight_sum);
    return (quotient > NumW'(DistMax)) ? DistMax : quotient[ChanW-1:0];
  endfunction

  // Pixel driver: holds the front item until the block takes it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_distances.push_back(weighted_distance(pending_pixels[0]));
        void'(pending_pixels.pop_front());
      end
      if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        start       <= 1'b1;
        pixel_hue_i <= pending_pixels[0].hue;
        pixel_sat_i <= pending_pixels[0].sat;
        pixel_val_i <= pending_pixels[0].val;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && color_distance_valid_o === 1'b1) begin
      if (expected_distances.size() == 0) begin
        $display("%0t: color_distance expected none, got %0d", $time, color_distance_o);
        error_count++;
      end else begin
        exp_distance = expected_distances.pop_front();
        if (color_distance_o !== exp_distance) begin
          $display("%0t: color_distance expected %0d, got %0d",
                   $time, exp_distance, color_distance_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || color_distance_valid_o || (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("** hsv_weighted_color_distance: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_register(input logic [IdxW-1:0] idx, input logic [DataW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // writes past the last register are dropped
    if (idx < NumRegs) target_and_weights[idx] = data[ChanW-1:0];
  endtask

  task automatic check_register(input logic [IdxW-1:0] idx);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= AddrW'({idx, 2'b00});
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== DataW'(target_and_weights[idx])) begin
      $display("%0t: register %0d read expected %0h, got %0h",
               $time, idx, target_and_weights[idx], prdata);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // upper data bits are junk; only the low byte lands in the register
  task automatic set_registers(input logic [ChanW-1:0] t_hue, input logic [ChanW-1:0] t_sat,
                               input logic [ChanW-1:0] t_val, input logic [ChanW-1:0] w_hue,
                               input logic [ChanW-1:0] w_sat, input logic [ChanW-1:0] w_val);
    write_register(hsvwcd_pkg::RegTargetHue, {24'($urandom_range(32'hFF_FFFF)), t_hue});
    write_register(hsvwcd_pkg::RegTargetSat, {24'($urandom_range(32'hFF_FFFF)), t_sat});
    write_register(hsvwcd_pkg::RegTargetVal, {24'($urandom_range(32'hFF_FFFF)), t_val});
    write_register(hsvwcd_pkg::RegHueWeight, {24'($urandom_range(32'hFF_FFFF)), w_hue});
    write_register(hsvwcd_pkg::RegSatWeight, {24'($urandom_range(32'hFF_FFFF)), w_sat});
    write_register(hsvwcd_pkg::RegValWeight, {24'($urandom_range(32'hFF_FFFF)), w_val});
    for (int i = 0; i < NumRegs; i++) check_register(IdxW'(i));
  endtask

  task automatic queue_pixel(input logic [ChanW-1:0] h, input logic [ChanW-1:0] s,
                             input logic [ChanW-1:0] v);
    pending_pixels.push_back('{hue: h, sat: s, val: v});
  endtask

  task automatic wait_drained();
    while (pending_pixels.size() != 0 || expected_distances.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [ChanW-1:0] pick_setting();
    case ($urandom_range(3))
      0:       return '0;
      1:       return DistMax;
      default: return ChanW'($urandom_range(255));
    endcase
  endfunction

  // channel value biased toward the edges and the hue wrap point
  function automatic logic [ChanW-1:0] pick_channel(logic [ChanW-1:0] target);
    case ($urandom_range(9))
      0:       return '0;
      1:       return DistMax;
      2:       return target;
      3:       return (target <= 8'd128) ? target + HueWrap : target - HueWrap;
      default: return ChanW'($urandom_range(255));
    endcase
  endfunction

  initial begin
    int unsigned idle_plan [4];
    idle_plan = '{0, 81, 0, 29};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all weights zero out of reset: distance is zero
    queue_pixel(8'd0, 8'd0, 8'd0);
    queue_pixel(8'd255, 8'd255, 8'd255);
    queue_pixel(8'd127, 8'd128, 8'd1);
    wait_drained();

    set_registers(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
    write_register(NumRegs, $urandom());
    write_register(IdxW'(NumRegs + 1), $urandom());
    queue_pixel(8'd255, 8'd255, 8'd255);   // saturates
    queue_pixel(8'd0, 8'd0, 8'd0);
    queue_pixel(8'd127, 8'd0, 8'd0);
    queue_pixel(8'd126, 8'd0, 8'd0);
    queue_pixel(8'd128, 8'd0, 8'd0);
    queue_pixel(8'd254, 8'd0, 8'd0);
    queue_pixel(8'd1, 8'd1, 8'd1);
    wait_drained();

    set_registers(8'd255, 8'd255, 8'd255, 8'd1, 8'd0, 8'd0);
    queue_pixel(8'd0, 8'd255, 8'd255);
    queue_pixel(8'd128, 8'd255, 8'd255);
    queue_pixel(8'd1, 8'd255, 8'd255);
    queue_pixel(8'd2, 8'd0, 8'd0);
    queue_pixel(8'd170, 8'd0, 8'd0);
    wait_drained();

    set_registers(8'd128, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1);
    queue_pixel(8'd255, 8'd255, 8'd255);
    queue_pixel(8'd0, 8'd0, 8'd85);
    queue_pixel(8'd1, 8'd0, 8'd86);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      set_registers(pick_setting(), pick_setting(), pick_setting(),
                    pick_setting(), pick_setting(), pick_setting());
      send_idle_pct = idle_plan[phase];
      for (int n = 0; n < PhaseItems; n++) begin
        queue_pixel(pick_channel(target_and_weights[hsvwcd_pkg::RegTargetHue]),
                    pick_channel(target_and_weights[hsvwcd_pkg::RegTargetSat]),
                    pick_channel(target_and_weights[hsvwcd_pkg::RegTargetVal]));
      end
      wait_drained();
    end

    repeat (Latency + 4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("** hsv_weighted_color_distance: PASSED **");
    end else begin
      $display("** hsv_weighted_color_distance: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/hsvwcd_pkg.sv
design/hsv_weighted_color_distance.sv
design/hsvwcd_checker.sv
verif/tb_hsv_weighted_color_distance.sv
